>>> src/xcpd_pkg.sv
// xcpd_pkg: shared types and constants for the xor checked packet deframer
// no dependencies; compiled first
package xcpd_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int POS_W  = 5;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_SUM  = 2'd3
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_LONG = 2'd3
    } t_kind;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  position;
        logic              last_payload;
    } t_result;

endpackage

>>> src/xcpd_if.sv
// xcpd_if: valid/ready channel interfaces for received bytes, results and config
// depends on nothing; compiled after xcpd_pkg

interface xcpd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface xcpd_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data;
    logic [4:0] position;
    logic       last_payload;

    modport source (output valid, output kind, output data, output position,
                    output last_payload, input ready);
    modport sink (input valid, input kind, input data, input position,
                  input last_payload, output ready);
endinterface

interface xcpd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] start_marker;

    modport source (output valid, output start_marker, input ready);
    modport sink (input valid, input start_marker, output ready);
endinterface

>>> src/xcpd_core.sv
// xcpd_core: frame state machine, length/count registers and running xor
// depends on xcpd_pkg
module xcpd_core #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_data,
    output xcpd_pkg::t_result     o_result
);
    import xcpd_pkg::*;

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int EXT_W = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);

    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic [BYTE_W-1:0] r_marker;

    logic [LEN_W:0]    cnt_inc;
    logic              last;
    logic [EXT_W-1:0]  pos_ext;

    assign cnt_inc = {1'b0, r_count} + 1'b1;
    assign last    = cnt_inc >= {1'b0, r_len};
    assign pos_ext = EXT_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_len    <= '0;
            r_count  <= '0;
            r_xor    <= '0;
            r_marker <= START_MARKER_RST;
        end else begin
            if (i_step) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_count <= n_count;
                r_xor   <= n_xor;
            end
            if (i_cfg_we) begin
                r_marker <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_count  = r_count;
        n_xor    = r_xor;
        o_result = '{valid: 1'b0, kind: KIND_DATA, data: i_rx_byte,
                     position: '0, last_payload: 1'b0};
        case (r_phase)
            PH_HUNT: begin
                if (i_rx_byte == r_marker) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_count = '0;
                n_xor   = '0;
                if (i_rx_byte > MAX_LEN) begin
                    n_len          = '0;
                    n_phase        = PH_HUNT;
                    o_result.valid = 1'b1;
                    o_result.kind  = KIND_LONG;
                end else begin
                    n_len   = i_rx_byte[LEN_W-1:0];
                    n_phase = (i_rx_byte == '0) ? PH_SUM : PH_DATA;
                end
            end
            PH_DATA: begin
                o_result.valid        = 1'b1;
                o_result.kind         = KIND_DATA;
                o_result.position     = pos_ext[POS_W-1:0];
                o_result.last_payload = last;
                n_xor                 = r_xor ^ i_rx_byte;
                n_count               = cnt_inc[LEN_W-1:0];
                if (last) begin
                    n_phase = PH_SUM;
                end
            end
            PH_SUM: begin
                o_result.valid = 1'b1;
                o_result.kind  = (i_rx_byte == r_xor) ? KIND_GOOD : KIND_BAD;
                n_phase        = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

endmodule

>>> src/xcpd_out_reg.sv
// xcpd_out_reg: result register between the deframer and the result channel
// depends on xcpd_pkg
module xcpd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  xcpd_pkg::t_result i_result,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output xcpd_pkg::t_result o_result
);
    import xcpd_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_in_ready = !r_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid && !i_out_ready;
        if (i_step && i_result.valid) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_result.valid) begin
            r_res <= i_result;
        end
    end

    always_comb begin
        o_result       = r_res;
        o_result.valid = r_valid;
    end

endmodule

>>> src/xor_checked_packet_deframer_top.sv
// channel   dir   payload                                 transfer
// i_rx      in    rx_byte                                 valid & ready
// o_res     out   kind, data, position, last_payload      valid & ready
// i_cfg     in    start_marker                            valid & ready
//
// one byte per cycle while i_rx is not stalled; each byte updates the frame state in the cycle it is taken
// a result is registered and appears on o_res in the cycle after its byte's transfer
// i_rx is stalled only while a result is held and o_res is not ready
// synchronous active-low reset returns to hunting with start marker 0xAA
// depends on xcpd_pkg, xcpd_if, xcpd_core, xcpd_out_reg
module xor_checked_packet_deframer_top #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    xcpd_rx_if.sink     i_rx,
    xcpd_res_if.source  o_res,
    xcpd_cfg_if.sink    i_cfg
);
    import xcpd_pkg::*;

    logic    step;
    logic    in_ready;
    t_result core_res;
    t_result out_res;

    assign i_rx.ready  = in_ready;
    assign step        = i_rx.valid && in_ready;
    assign i_cfg.ready = 1'b1;

    xcpd_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_rx_byte  (i_rx.rx_byte),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.start_marker),
        .o_result   (core_res)
    );

    xcpd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_result    (core_res),
        .i_out_ready (o_res.ready),
        .o_in_ready  (in_ready),
        .o_result    (out_res)
    );

    assign o_res.valid        = out_res.valid;
    assign o_res.kind         = out_res.kind;
    assign o_res.data         = out_res.data;
    assign o_res.position     = out_res.position;
    assign o_res.last_payload = out_res.last_payload;

endmodule

>>> tb/sv/tb_xor_checked_packet_deframer_top.sv
// tb_xor_checked_packet_deframer_top: self-checking bench for the xor checked deframer
// a directed table, then random frames, start-marker writes and noise
// depends on xcpd_pkg, xcpd_if and xor_checked_packet_deframer_top
module tb_xor_checked_packet_deframer_top;
    import xcpd_pkg::*;

    localparam int FRAME_MAX = 32;
    localparam int ITEM_GOAL = 1600;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  position;
        logic              last_payload;
    } t_expect;

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_op;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} t_check;

    typedef struct {
        t_row_op     op;
        logic [7:0]  value;
        t_check      chk;
        t_expect     exp;
    } t_row;

    localparam t_expect NO_RES = '{KIND_DATA, 8'h00, 5'd0, 1'b0};

    t_row directed_rows [0:26] = '{
        '{ROW_BYTE, 8'h00, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'hFF, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'hAA, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'h00, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'h00, CHK_TYPED, '{KIND_GOOD, 8'h00, 5'd0, 1'b0}},
        '{ROW_BYTE, 8'hAA, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'h00, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'h5A, CHK_TYPED, '{KIND_BAD, 8'h5A, 5'd0, 1'b0}},
        '{ROW_BYTE, 8'hAA, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'h21, CHK_TYPED, '{KIND_LONG, 8'h21, 5'd0, 1'b0}},
        '{ROW_BYTE, 8'hAA, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'hFF, CHK_TYPED, '{KIND_LONG, 8'hFF, 5'd0, 1'b0}},
        '{ROW_BYTE, 8'hAA, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'h02, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'hAA, CHK_MODEL, NO_RES},
        '{ROW_BYTE, 8'hFF, CHK_MODEL, NO_RES},
        '{ROW_BYTE, 8'h55, CHK_TYPED, '{KIND_GOOD, 8'h55, 5'd0, 1'b0}},
        '{ROW_CFG,  8'hFF, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'hAA, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'hFF, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'h01, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'h80, CHK_MODEL, NO_RES},
        '{ROW_BYTE, 8'h80, CHK_TYPED, '{KIND_GOOD, 8'h80, 5'd0, 1'b0}},
        '{ROW_CFG,  8'h00, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'h00, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'h00, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'h01, CHK_TYPED, '{KIND_BAD, 8'h01, 5'd0, 1'b0}}
    };

    logic clk;
    logic rst_n;

    xcpd_rx_if  rx_ch();
    xcpd_res_if res_ch();
    xcpd_cfg_if cfg_ch();

    xor_checked_packet_deframer_top #(
        .MAX_PAYLOAD(FRAME_MAX)
    ) DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_rx   (rx_ch),
        .o_res  (res_ch),
        .i_cfg  (cfg_ch)
    );

    // predicted deframer state
    t_phase      fr_phase;
    logic [5:0]  fr_len;
    logic [5:0]  fr_count;
    logic [7:0]  fr_xor;
    logic [7:0]  marker;

    t_expect     expected_q[$];
    int          err_count;
    int          live_items;
    bit          calm;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void deframe(input logic [7:0] b, output bit got, output t_expect r);
        bit last;
        got = 1'b0;
        r = NO_RES;
        case (fr_phase)
            PH_HUNT: begin
                if (b == marker) fr_phase = PH_LEN;
            end
            PH_LEN: begin
                fr_count = '0;
                fr_xor = '0;
                if (b > FRAME_MAX) begin
                    fr_len = '0;
                    fr_phase = PH_HUNT;
                    got = 1'b1;
                    r = '{KIND_LONG, b, 5'd0, 1'b0};
                end else begin
                    fr_len = b[5:0];
                    fr_phase = (b == 8'd0) ? PH_SUM : PH_DATA;
                end
            end
            PH_DATA: begin
                last = (int'(fr_count) + 1) >= int'(fr_len);
                got = 1'b1;
                r = '{KIND_DATA, b, fr_count[4:0], last};
                fr_xor = fr_xor ^ b;
                fr_count = fr_count + 6'd1;
                if (last) fr_phase = PH_SUM;
            end
            default: begin
                got = 1'b1;
                r = '{(b == fr_xor) ? KIND_GOOD : KIND_BAD, b, 5'd0, 1'b0};
                fr_phase = PH_HUNT;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input t_check chk, input t_expect typed);
        int gap;
        bit got;
        t_expect r;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
        if (fr_phase != PH_HUNT || b == marker) live_items++;
        deframe(b, got, r);
        if (chk == CHK_MODEL && got) expected_q.push_back(r);
        else if (chk == CHK_TYPED) expected_q.push_back(typed);
    endtask

    task automatic drain_results();
        rx_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_marker(input logic [7:0] v);
        drain_results();
        cfg_ch.valid        <= 1'b1;
        cfg_ch.start_marker <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        marker = v;
        cfg_ch.valid <= 1'b0;
    endtask

    // result sink with random stalls and checking
    initial begin : sink
        int stall;
        t_expect e;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid) @(posedge clk);
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer: kind %0d data %0h",
                       res_ch.kind, res_ch.data);
                err_count++;
            end else begin
                e = expected_q.pop_front();
                if (res_ch.kind !== e.kind) begin
                    $error("kind: expected %0d, actual %0d", e.kind, res_ch.kind);
                    err_count++;
                end
                if (res_ch.data !== e.data) begin
                    $error("data: expected %0h, actual %0h", e.data, res_ch.data);
                    err_count++;
                end
                if (res_ch.position !== e.position) begin
                    $error("position: expected %0d, actual %0d", e.position,
                           res_ch.position);
                    err_count++;
                end
                if (res_ch.last_payload !== e.last_payload) begin
                    $error("last_payload: expected %0b, actual %0b", e.last_payload,
                           res_ch.last_payload);
                    err_count++;
                end
            end
        end
    end

    initial begin : stim
        int pick;
        int len;
        int n;
        int next_cfg;
        logic [7:0] sum;
        logic [7:0] v;

        rst_n               <= 1'b0;
        rx_ch.valid         <= 1'b0;
        rx_ch.rx_byte       <= 8'h00;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.start_marker <= 8'h00;
        calm       = 1'b0;
        err_count  = 0;
        live_items = 0;
        fr_phase   = PH_HUNT;
        fr_len     = '0;
        fr_count   = '0;
        fr_xor     = '0;
        marker     = START_MARKER_RST;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].op == ROW_CFG)
                write_marker(directed_rows[i].value);
            else
                send_byte(directed_rows[i].value, directed_rows[i].chk, directed_rows[i].exp);
        end

        next_cfg = live_items + 100;
        while (live_items < ITEM_GOAL) begin
            if ($urandom_range(0, 9) == 0) calm = ~calm;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_byte(marker, CHK_MODEL, NO_RES);
                case ($urandom_range(0, 19))
                    0:       len = 0;
                    1:       len = FRAME_MAX;
                    2:       len = FRAME_MAX - 1;
                    3:       len = 1;
                    default: len = $urandom_range(1, 8);
                endcase
                send_byte(len[7:0], CHK_MODEL, NO_RES);
                // start-marker write in the middle of a frame
                if ($urandom_range(0, 19) == 0) write_marker(8'($urandom_range(0, 255)));
                sum = 8'h00;
                for (int k = 0; k < len; k++) begin
                    v = 8'($urandom_range(0, 255));
                    sum = sum ^ v;
                    send_byte(v, CHK_MODEL, NO_RES);
                end
                if ($urandom_range(0, 3) != 0) send_byte(sum, CHK_MODEL, NO_RES);
                else send_byte(8'($urandom_range(0, 255)), CHK_MODEL, NO_RES);
            end else if (pick < 80) begin
                send_byte(marker, CHK_MODEL, NO_RES);
                send_byte(8'($urandom_range(FRAME_MAX + 1, 255)), CHK_MODEL, NO_RES);
            end else if (pick < 88) begin
                // truncated frame, later bytes get absorbed into it
                send_byte(marker, CHK_MODEL, NO_RES);
                len = $urandom_range(2, 10);
                send_byte(len[7:0], CHK_MODEL, NO_RES);
                n = $urandom_range(0, len - 1);
                repeat (n) send_byte(8'($urandom_range(0, 255)), CHK_MODEL, NO_RES);
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom_range(0, 255)), CHK_MODEL, NO_RES);
            end
            if (live_items >= next_cfg) begin
                case ($urandom_range(0, 3))
                    0:       v = 8'h00;
                    1:       v = 8'hFF;
                    2:       v = START_MARKER_RST;
                    default: v = 8'($urandom_range(0, 255));
                endcase
                write_marker(v);
                next_cfg = live_items + $urandom_range(100, 200);
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (err_count == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/xcpd_pkg.sv
src/xcpd_if.sv
src/xcpd_core.sv
src/xcpd_out_reg.sv
src/xor_checked_packet_deframer_top.sv
tb/sv/tb_xor_checked_packet_deframer_top.sv
